@@ hw/rtl/thrm_pkg.sv @@
package thrm_pkg;

   // default divider sample width
   localparam int SampleBits = 12;

   // logarithm lanes
   localparam int LogSteps = 30;
   localparam int MantW    = 32;
   localparam int ExpW     = 5;
   localparam int LogW     = ExpW + LogSteps;
   localparam int L2W      = LogW + 2;
   localparam int NumLanes = 3;

   // ln 2 with 32 fraction bits
   localparam logic [31:0] Ln2Q32 = 32'd2977044472;

   // magnitudes of ln R and its powers, 30 fraction bits
   localparam int XmW    = 35;
   localparam int X2W    = 40;
   localparam int X3W    = 44;
   localparam int X2Half = 20;

   // curve arithmetic
   localparam int CoefW    = 48;
   localparam int CoefHalf = 24;
   localparam int ResW     = 20;
   localparam int ProdW    = 96;
   localparam int AccW     = 64;
   localparam int FracBits = 30;

   // kelvin division
   localparam int QW    = 17;
   localparam int QcmpW = AccW + QW;
   localparam logic [AccW-1:0] NumBase     = 64'd109951162777600;
   localparam logic [QW-1:0]   KelvinCenti = 17'd27315;
   localparam logic [QW-1:0]   QMax        = 17'd92850;
   localparam logic [QW-1:0]   TempMax     = 17'd65535;

   // register reset values
   localparam logic [CoefW-1:0] CoefAReset = 48'd1643549981;
   localparam logic [CoefW-1:0] CoefBReset = 48'd240815037;
   localparam logic [CoefW-1:0] CoefCReset = 48'd1785497;
   localparam logic [CoefW-1:0] CoefDReset = 48'd37873;
   localparam logic [ResW-1:0]  SeriesReset = 20'd4700;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_COEF_A = 3'd0,
      CSR_COEF_B = 3'd1,
      CSR_COEF_C = 3'd2,
      CSR_COEF_D = 3'd3,
      CSR_SERIES = 3'd4
   } csr_index_type;

   // position of the highest set bit, zero for zero
   function automatic logic [ExpW-1:0] msb_index(input logic [MantW-1:0] val);
      logic [ExpW-1:0] idx;
      idx = '0;
      for (int i = 0; i < MantW; i++) begin
         if (val[i]) begin
            idx = ExpW'(i);
         end
      end
      return idx;
   endfunction

endpackage

@@ hw/rtl/thermistor_temperature_top.sv @@
// thermistor divider sample to temperature in hundredths of a degree celsius
//
// req channel: one beat per divider sample, req_tdata low SAMPLE_BITS bits.
// rsp channel: one beat per sample, in order; rsp_tdata carries the signed
// 17-bit temperature, zero-extended; rsp_tuser flags a meaningless result
// (zero sample, zero series resistor, or a curve value that is not positive).
// csr port: single-cycle writes of the four curve coefficients and the
// series resistor; write only while no sample is in flight.
//
// an accepted req beat passes one input stage with normalization, 30 log
// squaring stages (one squaring per stage in each of three lanes), nine
// stages of ln and curve products, 17 stages of a one-bit-per-stage
// restoring divider and the output register on its way to the rsp beat.
// throughput is one sample per cycle while the rsp channel is not stalled.
// a stalled rsp channel holds the whole pipeline; req_tready drops in the
// same cycle, so nothing is dropped or repeated.
// reset clears all stage valid bits and loads the default coefficients and series resistor.
module thermistor_temperature_top #(
   parameter int SAMPLE_BITS = thrm_pkg::SampleBits
) (
   input  logic                 clock,
   input  logic                 reset,
   // fields: sample
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // fields: temperature_centi
   output logic [23:0]          rsp_tdata,
   // fields: invalid
   output logic                 rsp_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_we,
   input  logic [2:0]           csr_addr,
   input  logic [thrm_pkg::CoefW-1:0] csr_wdata
);

   localparam int LS  = thrm_pkg::LogSteps;
   localparam int MW  = thrm_pkg::MantW;
   localparam int EW  = thrm_pkg::ExpW;
   localparam int NL  = thrm_pkg::NumLanes;
   localparam int CW  = thrm_pkg::CoefW;
   localparam int CH  = thrm_pkg::CoefHalf;
   localparam int PW  = thrm_pkg::ProdW;
   localparam int AW  = thrm_pkg::AccW;
   localparam int FB  = thrm_pkg::FracBits;
   localparam int QW  = thrm_pkg::QW;
   localparam int QCW = thrm_pkg::QcmpW;
   localparam int XMW = thrm_pkg::XmW;
   localparam int X2W = thrm_pkg::X2W;
   localparam int X3W = thrm_pkg::X3W;
   localparam int X2H = thrm_pkg::X2Half;
   localparam int L2W = thrm_pkg::L2W;

   // configuration registers
   logic [CW-1:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic [thrm_pkg::ResW-1:0] series_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= thrm_pkg::CoefAReset;
         coef_b_ff <= thrm_pkg::CoefBReset;
         coef_c_ff <= thrm_pkg::CoefCReset;
         coef_d_ff <= thrm_pkg::CoefDReset;
         series_ff <= thrm_pkg::SeriesReset;
      end else if (csr_we) begin
         unique case (thrm_pkg::csr_index_type'(csr_addr))
            thrm_pkg::CSR_COEF_A: coef_a_ff <= csr_wdata;
            thrm_pkg::CSR_COEF_B: coef_b_ff <= csr_wdata;
            thrm_pkg::CSR_COEF_C: coef_c_ff <= csr_wdata;
            thrm_pkg::CSR_COEF_D: coef_d_ff <= csr_wdata;
            thrm_pkg::CSR_SERIES: series_ff <= csr_wdata[thrm_pkg::ResW-1:0];
            default: ;
         endcase
      end
   end

   // global advance: the pipeline moves unless a result waits
   logic ce;
   logic rsp_valid_ff;
   assign ce         = !rsp_valid_ff || rsp_tready;
   assign req_tready = ce;

   // input stage: operands of the three logs, normalized
   logic [SAMPLE_BITS-1:0] samp;
   logic [SAMPLE_BITS:0]   diff;
   logic [MW-1:0]          lane_val [NL];
   logic [EW-1:0]          lane_exp [NL];

   assign samp = req_tdata[SAMPLE_BITS-1:0];
   assign diff = {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, samp};
   assign lane_val[0] = MW'(series_ff);
   assign lane_val[1] = MW'(samp);
   assign lane_val[2] = MW'(diff);

   logic [MW-1:0] sq_m_ff    [LS+1][NL];
   logic [LS-1:0] sq_frac_ff [LS+1][NL];
   logic [EW-1:0] sq_e_ff    [LS+1][NL];
   logic          sq_vld_ff  [LS+1];
   logic          sq_bad_ff  [LS+1];

   for (genvar j = 0; j < NL; j++) begin : g_norm
      assign lane_exp[j] = thrm_pkg::msb_index(lane_val[j]);
      always_ff @(posedge clock) begin
         if (ce) begin
            sq_m_ff[0][j]    <= lane_val[j] << (EW'(MW - 1) - lane_exp[j]);
            sq_e_ff[0][j]    <= lane_exp[j];
            sq_frac_ff[0][j] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (ce) begin
         sq_vld_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sq_bad_ff[0] <= (samp == '0) || (series_ff == '0);
      end
   end

   // log fraction: one squaring of the mantissa per stage and lane
   for (genvar k = 1; k <= LS; k++) begin : g_sq
      for (genvar j = 0; j < NL; j++) begin : g_lane
         logic [2*MW-1:0] prod;
         logic [MW:0]     shr;
         assign prod = {{MW{1'b0}}, sq_m_ff[k-1][j]} * {{MW{1'b0}}, sq_m_ff[k-1][j]};
         assign shr  = prod[2*MW-1:MW-1];
         always_ff @(posedge clock) begin
            if (ce) begin
               sq_m_ff[k][j]    <= shr[MW] ? shr[MW:1] : shr[MW-1:0];
               sq_frac_ff[k][j] <= {sq_frac_ff[k-1][j][LS-2:0], shr[MW]};
               sq_e_ff[k][j]    <= sq_e_ff[k-1][j];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (ce) begin
            sq_vld_ff[k] <= sq_vld_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (ce) begin
            sq_bad_ff[k] <= sq_bad_ff[k-1];
         end
      end
   end

   // log2 of the resistance ratio
   logic signed [L2W-1:0] l2_in, l2_ff;
   logic l_vld_ff, l_bad_ff;

   assign l2_in = $signed({2'b00, sq_e_ff[LS][0], sq_frac_ff[LS][0]})
                + $signed({2'b00, sq_e_ff[LS][1], sq_frac_ff[LS][1]})
                - $signed({2'b00, sq_e_ff[LS][2], sq_frac_ff[LS][2]});

   // ln R magnitude and sign
   logic [L2W-1:0]     l2_abs;
   logic [L2W+31:0]    x_prod;
   logic [XMW-1:0]     x_mag_in, x_mag_ff;
   logic               x_neg_ff, x_vld_ff, x_bad_ff;

   assign l2_abs   = l2_ff[L2W-1] ? (~l2_ff + 1'b1) : l2_ff;
   assign x_prod   = (L2W+32)'(l2_abs) * (L2W+32)'(thrm_pkg::Ln2Q32)
                   + ((L2W+32)'(1) << 31);
   assign x_mag_in = x_prod[32+XMW-1:32];

   // x squared
   logic [2*XMW-1:0] x2_prod;
   logic [X2W-1:0]   x2_ff;
   logic [XMW-1:0]   x2_xm_ff;
   logic             x2_neg_ff, x2_vld_ff, x2_bad_ff;

   assign x2_prod = (2*XMW)'(x_mag_ff) * (2*XMW)'(x_mag_ff) + ((2*XMW)'(1) << (FB - 1));

   // x cubed, partial products then sum
   localparam int P3W = X2H + XMW;
   logic [P3W-1:0] p3_lo_ff, p3_hi_ff;
   logic [X2W-1:0] p3_x2_ff;
   logic [XMW-1:0] p3_xm_ff;
   logic           p3_neg_ff, p3_vld_ff, p3_bad_ff;

   logic [PW-1:0]  x3_sum;
   logic [X3W-1:0] x3_ff;
   logic [X2W-1:0] x3_x2_ff;
   logic [XMW-1:0] x3_xm_ff;
   logic           x3_neg_ff, x3_vld_ff, x3_bad_ff;

   assign x3_sum = (PW'(p3_hi_ff) << X2H) + PW'(p3_lo_ff) + (PW'(1) << (FB - 1));

   // coefficient partial products
   logic [CW-1:0] cb_mag, cc_mag, cd_mag;
   logic [PW-1:0] pb_lo_ff, pb_hi_ff, pc_lo_ff, pc_hi_ff, pd_lo_ff, pd_hi_ff;
   logic          pb_neg_ff, pc_neg_ff, pd_neg_ff, pp_vld_ff, pp_bad_ff;
   logic [CW-1:0] pp_a_ff;

   assign cb_mag = coef_b_ff[CW-1] ? (~coef_b_ff + 1'b1) : coef_b_ff;
   assign cc_mag = coef_c_ff[CW-1] ? (~coef_c_ff + 1'b1) : coef_c_ff;
   assign cd_mag = coef_d_ff[CW-1] ? (~coef_d_ff + 1'b1) : coef_d_ff;

   // rounded signed terms
   logic [PW-1:0] tb_sum, tc_sum, td_sum;
   logic signed [AW-1:0] tb_in, tc_in, td_in;
   logic signed [AW-1:0] term_a_ff, term_b_ff, term_c_ff, term_d_ff;
   logic t_vld_ff, t_bad_ff;

   assign tb_sum = (pb_hi_ff << CH) + pb_lo_ff + (PW'(1) << (FB - 1));
   assign tc_sum = (pc_hi_ff << CH) + pc_lo_ff + (PW'(1) << (FB - 1));
   assign td_sum = (pd_hi_ff << CH) + pd_lo_ff + (PW'(1) << (FB - 1));
   assign tb_in  = pb_neg_ff ? -$signed({1'b0, tb_sum[FB+AW-2:FB]})
                             :  $signed({1'b0, tb_sum[FB+AW-2:FB]});
   assign tc_in  = pc_neg_ff ? -$signed({1'b0, tc_sum[FB+AW-2:FB]})
                             :  $signed({1'b0, tc_sum[FB+AW-2:FB]});
   assign td_in  = pd_neg_ff ? -$signed({1'b0, td_sum[FB+AW-2:FB]})
                             :  $signed({1'b0, td_sum[FB+AW-2:FB]});

   // curve value
   logic signed [AW-1:0] s_ff;
   logic s_vld_ff, s_bad_ff;

   // division setup
   logic [AW-1:0]  num_in;
   logic           s_pos;

   assign s_pos  = !s_ff[AW-1] && (s_ff != '0);
   assign num_in = thrm_pkg::NumBase + {1'b0, s_ff[AW-1:1]};

   logic [AW-1:0] dv_rem_ff [QW+1];
   logic [AW-1:0] dv_den_ff [QW+1];
   logic [QW-1:0] dv_q_ff   [QW+1];
   logic          dv_ovf_ff [QW+1];
   logic          dv_bad_ff [QW+1];
   logic          dv_vld_ff [QW+1];

   // linear stages from log sum to division entry
   always_ff @(posedge clock) begin
      if (reset) begin
         l_vld_ff     <= 1'b0;
         x_vld_ff     <= 1'b0;
         x2_vld_ff    <= 1'b0;
         p3_vld_ff    <= 1'b0;
         x3_vld_ff    <= 1'b0;
         pp_vld_ff    <= 1'b0;
         t_vld_ff     <= 1'b0;
         s_vld_ff     <= 1'b0;
         dv_vld_ff[0] <= 1'b0;
      end else if (ce) begin
         l_vld_ff     <= sq_vld_ff[LS];
         x_vld_ff     <= l_vld_ff;
         x2_vld_ff    <= x_vld_ff;
         p3_vld_ff    <= x2_vld_ff;
         x3_vld_ff    <= p3_vld_ff;
         pp_vld_ff    <= x3_vld_ff;
         t_vld_ff     <= pp_vld_ff;
         s_vld_ff     <= t_vld_ff;
         dv_vld_ff[0] <= s_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         l2_ff    <= l2_in;
         l_bad_ff <= sq_bad_ff[LS];

         x_mag_ff <= x_mag_in;
         x_neg_ff <= l2_ff[L2W-1];
         x_bad_ff <= l_bad_ff;

         x2_ff     <= x2_prod[FB+X2W-1:FB];
         x2_xm_ff  <= x_mag_ff;
         x2_neg_ff <= x_neg_ff;
         x2_bad_ff <= x_bad_ff;

         p3_lo_ff  <= P3W'(x2_ff[X2H-1:0]) * P3W'(x2_xm_ff);
         p3_hi_ff  <= P3W'(x2_ff[X2W-1:X2H]) * P3W'(x2_xm_ff);
         p3_x2_ff  <= x2_ff;
         p3_xm_ff  <= x2_xm_ff;
         p3_neg_ff <= x2_neg_ff;
         p3_bad_ff <= x2_bad_ff;

         x3_ff     <= x3_sum[FB+X3W-1:FB];
         x3_x2_ff  <= p3_x2_ff;
         x3_xm_ff  <= p3_xm_ff;
         x3_neg_ff <= p3_neg_ff;
         x3_bad_ff <= p3_bad_ff;

         pb_lo_ff  <= PW'(cb_mag[CH-1:0]) * PW'(x3_xm_ff);
         pb_hi_ff  <= PW'(cb_mag[CW-1:CH]) * PW'(x3_xm_ff);
         pc_lo_ff  <= PW'(cc_mag[CH-1:0]) * PW'(x3_x2_ff);
         pc_hi_ff  <= PW'(cc_mag[CW-1:CH]) * PW'(x3_x2_ff);
         pd_lo_ff  <= PW'(cd_mag[CH-1:0]) * PW'(x3_ff);
         pd_hi_ff  <= PW'(cd_mag[CW-1:CH]) * PW'(x3_ff);
         pb_neg_ff <= coef_b_ff[CW-1] ^ x3_neg_ff;
         pc_neg_ff <= coef_c_ff[CW-1];
         pd_neg_ff <= coef_d_ff[CW-1] ^ x3_neg_ff;
         pp_a_ff   <= coef_a_ff;
         pp_bad_ff <= x3_bad_ff;

         term_a_ff <= AW'($signed(pp_a_ff));
         term_b_ff <= tb_in;
         term_c_ff <= tc_in;
         term_d_ff <= td_in;
         t_bad_ff  <= pp_bad_ff;

         s_ff     <= term_a_ff + term_b_ff + term_c_ff + term_d_ff;
         s_bad_ff <= t_bad_ff;

         dv_rem_ff[0] <= num_in;
         dv_den_ff[0] <= s_ff;
         dv_q_ff[0]   <= '0;
         dv_ovf_ff[0] <= QCW'(num_in) >= {s_ff, {QW{1'b0}}};
         dv_bad_ff[0] <= s_bad_ff || !s_pos;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar i = 1; i <= QW; i++) begin : g_div
      logic [QCW-1:0] shifted;
      logic           ge;
      assign shifted = QCW'(dv_den_ff[i-1]) << (QW - i);
      assign ge      = QCW'(dv_rem_ff[i-1]) >= shifted;
      always_ff @(posedge clock) begin
         if (ce) begin
            dv_rem_ff[i] <= ge ? (dv_rem_ff[i-1] - shifted[AW-1:0]) : dv_rem_ff[i-1];
            dv_den_ff[i] <= dv_den_ff[i-1];
            dv_q_ff[i]   <= {dv_q_ff[i-1][QW-2:0], ge};
            dv_ovf_ff[i] <= dv_ovf_ff[i-1];
            dv_bad_ff[i] <= dv_bad_ff[i-1];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[i] <= 1'b0;
         end else if (ce) begin
            dv_vld_ff[i] <= dv_vld_ff[i-1];
         end
      end
   end

   // kelvin to celsius with saturation, output register
   logic [QW-1:0] temp_in, temp_ff;
   logic          inv_ff;

   always_comb begin
      priority if (dv_bad_ff[QW]) begin
         temp_in = '0;
      end else if (dv_ovf_ff[QW] || (dv_q_ff[QW] > thrm_pkg::QMax)) begin
         temp_in = thrm_pkg::TempMax;
      end else begin
         temp_in = dv_q_ff[QW] - thrm_pkg::KelvinCenti;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ce) begin
         rsp_valid_ff <= dv_vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         temp_ff <= temp_in;
         inv_ff  <= dv_bad_ff[QW];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, temp_ff};
   assign rsp_tuser  = inv_ff;

   // an invalid result carries a zero temperature
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && inv_ff |-> temp_ff == '0)
      else $error("invalid result with nonzero temperature");

   // a valid temperature never falls below absolute zero
   a_temp_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !inv_ff |-> $signed(temp_ff) >= -$signed({1'b0, thrm_pkg::KelvinCenti}))
      else $error("temperature below absolute zero");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !sq_vld_ff[0] && !dv_vld_ff[0])
      else $error("pipeline holds a beat after reset");

   // a stalled output holds its result
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(temp_ff) && $stable(inv_ff))
      else $error("stalled result changed");

endmodule
